>>> hw/rtl/gdau_pkg.sv
// ----------------------------------------------------------------------------
// gdau_pkg
// types, constants and helpers shared by the gregorian date unit
// ----------------------------------------------------------------------------
package gdau_pkg;

  typedef enum logic [2:0] {
    CMD_CHECK   = 3'd0,
    CMD_DOY     = 3'd1,
    CMD_DIFF    = 3'd2,
    CMD_ADD     = 3'd3,
    CMD_WEEKDAY = 3'd4
  } cmd_e;

  localparam int unsigned YearW = 14;
  localparam int unsigned CountW = 23;
  localparam int unsigned DayNumW = 26;

  // cumulative days before each month, common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] r;
    case (m)
      4'd2:                       r = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      default:                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/gregorian_date_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit
// proleptic gregorian date checks, day of year, difference, add and weekday
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   cmd, dates a and b, day offset
// m_axis   out  possible, error, result date, day count, weekday
//
// one request per cycle while the output register is not stalled; each request
// passes seven register stages before its result is offered.
// the depth is set by the day-number to date conversion: a reciprocal multiply
// for the year estimate, a year correction and a month search.
// reset clears the valid bits only; a stall freezes every stage in place
// and ready falls only when the output register is full and not taken.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_unit
  import gdau_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[2:0] year_a[16:3] month_a[20:17] day_a[25:21] year_b[39:26]
  // month_b[43:40] day_b[48:44] offset[71:49]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // possible[0] error[1] result_year[15:2] result_month[19:16]
  // result_day[24:20] day_count[47:25] weekday[50:48]
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned NStg = 7;
  localparam logic [DayNumW-1:0] LastDay =
    DayNumW'(365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4 - (MAX_YEAR + 100) / 100
             + (MAX_YEAR + 400) / 400 - 1);

  logic [NStg-1:0] vld_q;
  logic            adv;
  assign adv = m_axis_tready | ~vld_q[NStg-1];
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  // multiple of 25: times the inverse of 25 mod 2^16 stays small
  function automatic logic mult25(input logic [15:0] y);
    logic [15:0] p;
    p = 16'(y * 16'd23593);
    return p <= 16'd2621;
  endfunction

  function automatic logic is_leap(input logic [15:0] y);
    return (y[1:0] == 2'd0) && (!mult25(y) || y[3:0] == 4'd0);
  endfunction

  // quotient by 25 through a reciprocal multiply
  function automatic logic [11:0] div25(input logic [15:0] z);
    logic [31:0] p;
    p = 32'(z) * 32'd41944;
    return p[31:20];
  endfunction

  function automatic logic [DayNumW-1:0] days_before(input logic [16:0] y);
    logic [17:0] a4, a100, a400;
    logic [11:0] c100, c400;
    a4 = {1'b0, y} + 18'd3;
    a100 = {1'b0, y} + 18'd99;
    a400 = {1'b0, y} + 18'd399;
    c100 = div25(a100[17:2]);
    c400 = div25({2'b0, a400[17:4]});
    return DayNumW'(y) * DayNumW'(365) + DayNumW'(a4[17:2]) - DayNumW'(c100)
           + DayNumW'(c400);
  endfunction

  // remainder by 7 from the sum of octal digits
  function automatic logic [2:0] mod7(input logic [DayNumW-1:0] n);
    logic [26:0] x;
    logic [5:0]  s;
    logic [3:0]  t;
    x = 27'(n);
    s = '0;
    for (int i = 0; i < 9; i++) s = s + 6'(x[3*i +: 3]);
    t = 4'(s[5:3]) + 4'(s[2:0]);
    if (t >= 4'd14) return 3'd0;
    else if (t >= 4'd7) return 3'(t - 4'd7);
    else return t[2:0];
  endfunction

  logic [2:0]  in_cmd;
  logic [13:0] ya, yb;
  logic [3:0]  ma, mb;
  logic [4:0]  da, db;
  logic signed [22:0] off;
  assign in_cmd = s_axis_tdata[2:0];
  assign ya = s_axis_tdata[16:3];
  assign ma = s_axis_tdata[20:17];
  assign da = s_axis_tdata[25:21];
  assign yb = s_axis_tdata[39:26];
  assign mb = s_axis_tdata[43:40];
  assign db = s_axis_tdata[48:44];
  assign off = s_axis_tdata[71:49];

  // ---------------- stage 1: validate, day of year, days before year
  typedef struct packed {
    logic [2:0]          cmd;
    logic                pa;
    logic                pb;
    logic [8:0]          doy;
    logic [8:0]          doyb;
    logic [DayNumW-1:0]  dba;
    logic [DayNumW-1:0]  dbb;
    logic signed [22:0]  off;
  } s1_t;
  s1_t s1_d, s1_q;
  always_comb begin
    logic la, lb;
    la = is_leap({2'b0, ya});
    lb = is_leap({2'b0, yb});
    s1_d.cmd = in_cmd;
    s1_d.pa = ({2'b0, ya} <= 16'(MAX_YEAR)) && da != 5'd0 && da <= month_len(ma, la);
    s1_d.pb = ({2'b0, yb} <= 16'(MAX_YEAR)) && db != 5'd0 && db <= month_len(mb, lb);
    s1_d.doy = cum_days(ma) + 9'((la && ma > 4'd2) ? 1 : 0) + 9'(da) - 9'd1;
    s1_d.doyb = cum_days(mb) + 9'((lb && mb > 4'd2) ? 1 : 0) + 9'(db) - 9'd1;
    s1_d.dba = days_before({3'b0, ya});
    s1_d.dbb = days_before({3'b0, yb});
    s1_d.off = off;
  end

  // ---------------- stage 2: day numbers and sum
  typedef struct packed {
    logic [2:0]          cmd;
    logic                pa;
    logic                pb;
    logic [8:0]          doy;
    logic [DayNumW-1:0]  dna;
    logic [DayNumW-1:0]  dnb;
    logic signed [DayNumW:0] sum;
  } s2_t;
  s2_t s2_d, s2_q;
  always_comb begin
    s2_d.cmd = s1_q.cmd;
    s2_d.pa = s1_q.pa;
    s2_d.pb = s1_q.pb;
    s2_d.doy = s1_q.doy;
    s2_d.dna = s1_q.dba + DayNumW'(s1_q.doy);
    s2_d.dnb = s1_q.dbb + DayNumW'(s1_q.doyb);
    s2_d.sum = $signed({1'b0, s1_q.dba}) + $signed({18'b0, s1_q.doy})
               + (DayNumW+1)'(s1_q.off);
  end

  // ---------------- stage 3: range, diff, weekday, year estimate
  typedef struct packed {
    logic [2:0]          cmd;
    logic                pa;
    logic                pb;
    logic                oor;
    logic [8:0]          doy;
    logic signed [DayNumW:0] diff;
    logic [2:0]          wd;
    logic [DayNumW-1:0]  n;
    logic [15:0]         y;
  } s3_t;
  s3_t s3_d, s3_q;
  always_comb begin
    logic [2:0]  w;
    logic [53:0] prod;
    s3_d.cmd = s2_q.cmd;
    s3_d.pa = s2_q.pa;
    s3_d.pb = s2_q.pb;
    s3_d.doy = s2_q.doy;
    s3_d.oor = s2_q.sum < 0 || s2_q.sum > $signed({1'b0, LastDay});
    s3_d.diff = $signed({1'b0, s2_q.dna}) - $signed({1'b0, s2_q.dnb});
    // 2000-01-02 is day 730486, which is 1 mod 7
    w = mod7(s2_q.dna);
    s3_d.wd = (w == 3'd0) ? 3'd6 : w - 3'd1;
    s3_d.n = s2_q.sum[DayNumW-1:0];
    // year estimate n*400/146097 as n*K >> 36
    prod = 54'(s2_q.sum[DayNumW-1:0]) * 54'd188147536;
    s3_d.y = prod[51:36];
  end

  // ---------------- stage 4: year bounds
  typedef struct packed {
    logic [2:0]          cmd;
    logic                pa;
    logic                pb;
    logic                oor;
    logic [8:0]          doy;
    logic signed [DayNumW:0] diff;
    logic [2:0]          wd;
    logic [DayNumW-1:0]  n;
    logic [15:0]         y;
    logic [DayNumW-1:0]  dbm;
    logic [DayNumW-1:0]  db0;
    logic [DayNumW-1:0]  db1;
    logic                lpm;
    logic                lp0;
    logic                lp1;
  } s4_t;
  s4_t s4_d, s4_q;
  always_comb begin
    s4_d.cmd = s3_q.cmd;
    s4_d.pa = s3_q.pa;
    s4_d.pb = s3_q.pb;
    s4_d.oor = s3_q.oor;
    s4_d.doy = s3_q.doy;
    s4_d.diff = s3_q.diff;
    s4_d.wd = s3_q.wd;
    s4_d.n = s3_q.n;
    s4_d.y = s3_q.y;
    s4_d.dbm = days_before({1'b0, s3_q.y} - 17'd1);
    s4_d.db0 = days_before({1'b0, s3_q.y});
    s4_d.db1 = days_before({1'b0, s3_q.y} + 17'd1);
    s4_d.lpm = is_leap(s3_q.y - 16'd1);
    s4_d.lp0 = is_leap(s3_q.y);
    s4_d.lp1 = is_leap(s3_q.y + 16'd1);
  end

  // ---------------- stage 5: year correction, day within year
  typedef struct packed {
    logic [2:0]          cmd;
    logic                pa;
    logic                pb;
    logic                oor;
    logic [8:0]          doy;
    logic signed [DayNumW:0] diff;
    logic [2:0]          wd;
    logic [15:0]         y;
    logic                lp;
    logic [8:0]          r;
  } s5_t;
  s5_t s5_d, s5_q;
  always_comb begin
    logic [15:0] y;
    logic [DayNumW-1:0] r;
    logic lp;
    if (s4_q.n >= s4_q.db1) begin
      y = s4_q.y + 16'd1;
      r = s4_q.n - s4_q.db1;
      lp = s4_q.lp1;
    end else if (s4_q.n < s4_q.db0) begin
      y = s4_q.y - 16'd1;
      r = s4_q.n - s4_q.dbm;
      lp = s4_q.lpm;
    end else begin
      y = s4_q.y;
      r = s4_q.n - s4_q.db0;
      lp = s4_q.lp0;
    end
    s5_d.cmd = s4_q.cmd;
    s5_d.pa = s4_q.pa;
    s5_d.pb = s4_q.pb;
    s5_d.oor = s4_q.oor;
    s5_d.doy = s4_q.doy;
    s5_d.diff = s4_q.diff;
    s5_d.wd = s4_q.wd;
    s5_d.y = y;
    s5_d.lp = lp;
    s5_d.r = r[8:0];
  end

  // ---------------- stage 6: month search
  typedef struct packed {
    logic [2:0]          cmd;
    logic                pa;
    logic                pb;
    logic                oor;
    logic [8:0]          doy;
    logic signed [DayNumW:0] diff;
    logic [2:0]          wd;
    logic [15:0]         y;
    logic [3:0]          m;
    logic [4:0]          d;
  } s6_t;
  s6_t s6_d, s6_q;
  always_comb begin
    logic [3:0] m;
    logic [8:0] st;
    m = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      st = cum_days(4'(i)) + 9'((s5_q.lp && i > 2) ? 1 : 0);
      if (s5_q.r >= st) m = 4'(i);
    end
    st = cum_days(m) + 9'((s5_q.lp && m > 4'd2) ? 1 : 0);
    s6_d.cmd = s5_q.cmd;
    s6_d.pa = s5_q.pa;
    s6_d.pb = s5_q.pb;
    s6_d.oor = s5_q.oor;
    s6_d.doy = s5_q.doy;
    s6_d.diff = s5_q.diff;
    s6_d.wd = s5_q.wd;
    s6_d.y = s5_q.y;
    s6_d.m = m;
    s6_d.d = 5'(s5_q.r - st + 9'd1);
  end

  // ---------------- stage 7: result select
  logic [55:0] out_d, out_q;
  always_comb begin
    logic err;
    logic [13:0] ry;
    logic [3:0] rm;
    logic [4:0] rd;
    logic [22:0] cnt;
    logic [2:0] wd;
    err = 1'b0; ry = '0; rm = '0; rd = '0; cnt = '0; wd = '0;
    case (s6_q.cmd)
      CMD_CHECK: err = ~s6_q.pa;
      CMD_DOY: begin
        if (!s6_q.pa) err = 1'b1;
        else cnt = 23'(s6_q.doy);
      end
      CMD_DIFF: begin
        if (!s6_q.pa || !s6_q.pb) err = 1'b1;
        else if (s6_q.diff > 27'sd4194303) cnt = 23'h3FFFFF;
        else if (s6_q.diff < -27'sd4194304) cnt = 23'h400000;
        else cnt = s6_q.diff[22:0];
      end
      CMD_ADD: begin
        if (!s6_q.pa || s6_q.oor) err = 1'b1;
        else begin
          ry = s6_q.y[13:0];
          rm = s6_q.m;
          rd = s6_q.d;
        end
      end
      CMD_WEEKDAY: begin
        if (!s6_q.pa) err = 1'b1;
        else wd = s6_q.wd;
      end
      default: err = 1'b1;
    endcase
    out_d = {5'b0, wd, cnt, rd, rm, ry, err, s6_q.pa};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
      out_q <= out_d;
    end
  end
  assign m_axis_tdata = out_q;

  a_err_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("impossible date without error");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result lost under stall");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[50:2] == '0)
    else $error("fields set with error");

endmodule
